// ===== rtl/core/imf_pkg.sv =====
// ----------------------------------------------------------------------------
// imf_pkg
// shared widths, codes, control word layout and microcode program of the
// metropolis spin-flip engine
// ----------------------------------------------------------------------------
`default_nettype none

package imf_pkg;

    localparam int SIDE_DEFAULT = 64;

    localparam int ROW_W        = 6;
    localparam int COORD_VALUES = 2 ** ROW_W;
    localparam int FRAC_W       = 32;
    localparam int DE_W         = 5;
    localparam int MAG_W        = 14;
    localparam int EN_W         = 15;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ATTEMPT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_4  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_8  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 2'd2;

    typedef logic [2:0] step_t;

    localparam step_t STEP_WAIT   = 3'd0;
    localparam step_t STEP_SITE   = 3'd1;
    localparam step_t STEP_WEST   = 3'd2;
    localparam step_t STEP_EAST   = 3'd3;
    localparam step_t STEP_NORTH  = 3'd4;
    localparam step_t STEP_SOUTH  = 3'd5;
    localparam step_t STEP_COMMIT = 3'd6;

    typedef enum logic [2:0] {
        SEL_SITE,
        SEL_WEST,
        SEL_EAST,
        SEL_NORTH,
        SEL_SOUTH
    } addr_sel_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_ITEM,
        COND_OUT
    } cond_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      cap_site;
        logic      acc_nb;
        logic      commit;
        cond_t     cond;
        step_t     next_step;
    } ctrl_t;

    function automatic ctrl_t microcode(input step_t step);
        ctrl_t w;
        w = '{addr_sel: SEL_SITE, cap_site: 1'b0, acc_nb: 1'b0, commit: 1'b0,
              cond: COND_ITEM, next_step: STEP_SITE};
        case (step)
            STEP_WAIT:
            begin
                w.cond      = COND_ITEM;
                w.next_step = STEP_SITE;
            end
            STEP_SITE:
            begin
                w.cond      = COND_ALWAYS;
                w.next_step = STEP_WEST;
            end
            STEP_WEST:
            begin
                w.addr_sel  = SEL_WEST;
                w.cap_site  = 1'b1;
                w.cond      = COND_ALWAYS;
                w.next_step = STEP_EAST;
            end
            STEP_EAST:
            begin
                w.addr_sel  = SEL_EAST;
                w.acc_nb    = 1'b1;
                w.cond      = COND_ALWAYS;
                w.next_step = STEP_NORTH;
            end
            STEP_NORTH:
            begin
                w.addr_sel  = SEL_NORTH;
                w.acc_nb    = 1'b1;
                w.cond      = COND_ALWAYS;
                w.next_step = STEP_SOUTH;
            end
            STEP_SOUTH:
            begin
                w.addr_sel  = SEL_SOUTH;
                w.acc_nb    = 1'b1;
                w.cond      = COND_ALWAYS;
                w.next_step = STEP_COMMIT;
            end
            STEP_COMMIT:
            begin
                w.addr_sel  = SEL_SITE;
                w.commit    = 1'b1;
                w.cond      = COND_OUT;
                w.next_step = STEP_WAIT;
            end
            default:
            begin
                w.cond      = COND_ALWAYS;
                w.next_step = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/imf_item_if.sv =====
// ----------------------------------------------------------------------------
// imf_item_if
// input channel: load and flip-attempt beats
// ----------------------------------------------------------------------------
`default_nettype none

interface imf_item_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [imf_pkg::ROW_W-1:0]     row;
    logic [imf_pkg::ROW_W-1:0]     col;
    logic                          spin_value;
    logic [imf_pkg::FRAC_W-1:0]    random_fraction;

    modport source (output valid, cmd, row, col, spin_value, random_fraction, input ready);
    modport sink   (input valid, cmd, row, col, spin_value, random_fraction, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/imf_result_if.sv =====
// ----------------------------------------------------------------------------
// imf_result_if
// output channel: one result beat per input beat
// ----------------------------------------------------------------------------
`default_nettype none

interface imf_result_if;
    logic                              valid;
    logic                              ready;
    logic                              flipped;
    logic                              spin_now;
    logic signed [imf_pkg::DE_W-1:0]   delta_energy;
    logic signed [imf_pkg::MAG_W-1:0]  magnetization;
    logic signed [imf_pkg::EN_W-1:0]   energy;

    modport source (output valid, flipped, spin_now, delta_energy, magnetization, energy,
                    input ready);
    modport sink   (input valid, flipped, spin_now, delta_energy, magnetization, energy,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ising_metropolis_flip.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_flip
// metropolis spin-flip engine on a SIDE x SIDE torus of one-bit spins
// ----------------------------------------------------------------------------
// item channel: a load beat writes one spin, an attempt beat proposes a
// flip at (row, col) and brings a 32-bit uniform fraction. row and col wrap
// modulo SIDE. every item beat gives exactly one result beat carrying the
// flip flag, the new site spin, the applied energy change and the running
// magnetization and bond energy.
// configuration: cfg_we writes cfg_data to register cfg_index (0 level for
// a rise of 4J, 1 level for 8J, 2 antiferromagnetic coupling); write only
// while no item is in flight.
// timing: a new item is taken only after the last one commits; the pace is
// set by the five reads and one write of the single-port lattice memory
// stepped by the microcode program. the result is registered at commit.
// reset: the lattice is swept to all +1, one site a cycle, across all SIDE*SIDE
// sites (4096 at SIDE = 64); item ready stays low during the sweep.
// stall: a result waits in its register; the next item is taken meanwhile
// and its work holds at the final step until the result slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_flip #(
    parameter int SIDE = imf_pkg::SIDE_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    imf_item_if.sink                               item,
    imf_result_if.source                           result,
    input  wire logic                              cfg_we,
    input  wire logic [imf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [imf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SITES = SIDE * SIDE;
    localparam int CW    = $clog2(SIDE);
    localparam int AW    = $clog2(SITES);

    localparam logic [CW-1:0]             COORD_MAX = CW'(SIDE - 1);
    localparam logic [AW-1:0]             ADDR_LAST = AW'(SITES - 1);
    localparam logic [imf_pkg::MAG_W-1:0] MAG_INIT  = imf_pkg::MAG_W'(SITES);
    localparam logic [imf_pkg::EN_W-1:0]  EN_INIT   = imf_pkg::EN_W'(-2 * SITES);

    imf_pkg::ctrl_t ctrl;

    logic [CW-1:0] coord_mod [imf_pkg::COORD_VALUES];

    for (genvar i = 0; i < imf_pkg::COORD_VALUES; i++)
    begin : g_coord
        assign coord_mod[i] = CW'(i % SIDE);
    end

    // configuration
    logic [imf_pkg::FRAC_W-1:0] level4_reg;
    logic [imf_pkg::FRAC_W-1:0] level8_reg;
    logic                       coupling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level4_reg   <= '0;
            level8_reg   <= '0;
            coupling_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imf_pkg::CFG_LEVEL_4:  level4_reg   <= cfg_data;
                imf_pkg::CFG_LEVEL_8:  level8_reg   <= cfg_data;
                imf_pkg::CFG_COUPLING: coupling_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // clearing sweep
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_LAST)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // handshakes
    logic item_taken;
    logic out_free;
    logic commit_fire;

    assign item.ready  = (ctrl.cond == imf_pkg::COND_ITEM) && !clr_busy_reg;
    assign item_taken  = item.valid && item.ready;
    assign out_free    = !result.valid || result.ready;
    assign commit_fire = ctrl.commit && out_free;

    imf_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_taken (item_taken),
        .out_free   (out_free),
        .ctrl       (ctrl)
    );

    // item capture
    logic                       cmd_reg;
    logic                       load_bit_reg;
    logic [CW-1:0]              row_reg;
    logic [CW-1:0]              col_reg;
    logic [imf_pkg::FRAC_W-1:0] frac_reg;

    always_ff @(posedge clk)
    begin
        if (item_taken)
        begin
            cmd_reg      <= item.cmd;
            load_bit_reg <= item.spin_value;
            row_reg      <= coord_mod[item.row];
            col_reg      <= coord_mod[item.col];
            frac_reg     <= item.random_fraction;
        end
    end

    // neighbour coordinates on the torus
    logic [CW-1:0] col_w;
    logic [CW-1:0] col_e;
    logic [CW-1:0] row_n;
    logic [CW-1:0] row_s;
    logic [CW-1:0] sel_row;
    logic [CW-1:0] sel_col;
    logic [AW-1:0] sel_addr;

    assign col_w = (col_reg == '0) ? COORD_MAX : col_reg - 1'b1;
    assign col_e = (col_reg == COORD_MAX) ? '0 : col_reg + 1'b1;
    assign row_n = (row_reg == '0) ? COORD_MAX : row_reg - 1'b1;
    assign row_s = (row_reg == COORD_MAX) ? '0 : row_reg + 1'b1;

    always_comb
    begin
        sel_row = row_reg;
        sel_col = col_reg;
        case (ctrl.addr_sel)
            imf_pkg::SEL_SITE:  ;
            imf_pkg::SEL_WEST:  sel_col = col_w;
            imf_pkg::SEL_EAST:  sel_col = col_e;
            imf_pkg::SEL_NORTH: sel_row = row_n;
            imf_pkg::SEL_SOUTH: sel_row = row_s;
            default:            ;
        endcase
    end

    assign sel_addr  = AW'(sel_row) * AW'(SIDE) + AW'(sel_col);

    // lattice memory, single port
    logic          lattice [SITES];
    logic          mem_we;
    logic          mem_wdata;
    logic [AW-1:0] mem_addr;
    logic          rd_data_reg;
    logic          flip;

    assign mem_we    = clr_busy_reg || (commit_fire && flip);
    assign mem_addr  = clr_busy_reg ? clr_addr_reg : sel_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lattice[mem_addr] <= mem_wdata;
        end
        // south neighbour held while the result slot is busy
        if (!ctrl.commit)
        begin
            rd_data_reg <= lattice[mem_addr];
        end
    end

    // site and neighbour count
    logic       site_reg;
    logic [2:0] nb_cnt_reg;
    logic [2:0] nb_cnt;

    assign nb_cnt = nb_cnt_reg + 3'(rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_site)
        begin
            site_reg   <= rd_data_reg;
            nb_cnt_reg <= '0;
        end
        else if (ctrl.acc_nb)
        begin
            nb_cnt_reg <= nb_cnt;
        end
    end

    // energy change and decision
    logic signed [5:0] pair_term;
    logic signed [5:0] ferro_change;
    logic signed [5:0] de;

    assign pair_term    = $signed({1'b0, nb_cnt, 2'b00}) - 6'sd8;
    assign ferro_change = site_reg ? pair_term : -pair_term;
    assign de           = coupling_reg ? -ferro_change : ferro_change;
    assign mem_wdata    = clr_busy_reg ? 1'b1 : ~site_reg;

    always_comb
    begin
        if (cmd_reg == imf_pkg::CMD_ATTEMPT)
        begin
            if (de <= 6'sd0)
            begin
                flip = 1'b1;
            end
            else if (de == 6'sd4)
            begin
                flip = frac_reg < level4_reg;
            end
            else
            begin
                flip = frac_reg < level8_reg;
            end
        end
        else
        begin
            flip = site_reg != load_bit_reg;
        end
    end

    // running sums and result register
    logic        [imf_pkg::MAG_W-1:0] spin_sum_reg;
    logic        [imf_pkg::MAG_W-1:0] spin_sum_next;
    logic        [imf_pkg::EN_W-1:0]  bond_reg;
    logic        [imf_pkg::EN_W-1:0]  bond_next;
    logic                             out_valid_reg;
    logic                             flipped_reg;
    logic                             spin_now_reg;
    logic signed [imf_pkg::DE_W-1:0]  de_reg;
    logic signed [imf_pkg::EN_W-1:0]  energy_reg;

    always_comb
    begin
        spin_sum_next = spin_sum_reg;
        bond_next     = bond_reg;
        if (flip)
        begin
            spin_sum_next = site_reg ? spin_sum_reg - imf_pkg::MAG_W'(2)
                                     : spin_sum_reg + imf_pkg::MAG_W'(2);
            bond_next     = bond_reg + imf_pkg::EN_W'(ferro_change);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_sum_reg  <= MAG_INIT;
            bond_reg      <= EN_INIT;
            out_valid_reg <= 1'b0;
        end
        else if (commit_fire)
        begin
            spin_sum_reg  <= spin_sum_next;
            bond_reg      <= bond_next;
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_fire)
        begin
            flipped_reg  <= flip;
            spin_now_reg <= site_reg ^ flip;
            de_reg       <= flip ? imf_pkg::DE_W'(de) : '0;
            energy_reg   <= coupling_reg ? -$signed(bond_next) : $signed(bond_next);
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.flipped       = flipped_reg;
    assign result.spin_now      = spin_now_reg;
    assign result.delta_energy  = de_reg;
    assign result.magnetization = $signed(spin_sum_reg);
    assign result.energy        = energy_reg;

`ifndef SYNTH
    a_no_item_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !item.ready)
        else $error("item taken during lattice sweep");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit_fire |=> result.valid)
        else $error("committed item left no result");

    a_no_flip_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.flipped) |-> (result.delta_energy == '0))
        else $error("energy change reported without a flip");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/imf_sequencer.sv =====
// ----------------------------------------------------------------------------
// imf_sequencer
// step counter over the microcode table, with held steps for the input
// beat and for a free result slot
// ----------------------------------------------------------------------------
`default_nettype none

module imf_sequencer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_taken,
    input  wire logic           out_free,
    output imf_pkg::ctrl_t      ctrl
);

    imf_pkg::step_t step_reg;
    imf_pkg::step_t step_next;

    always_comb
    begin
        ctrl = imf_pkg::microcode(step_reg);
    end

    always_comb
    begin
        case (ctrl.cond)
            imf_pkg::COND_ALWAYS: step_next = ctrl.next_step;
            imf_pkg::COND_ITEM:   step_next = item_taken ? ctrl.next_step : step_reg;
            imf_pkg::COND_OUT:    step_next = out_free ? ctrl.next_step : step_reg;
            default:              step_next = imf_pkg::STEP_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= imf_pkg::STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== dv/imf_flip_checker.sv =====
// ----------------------------------------------------------------------------
// imf_flip_checker
// watches the item, result and configuration ports of the spin-flip engine,
// keeps its own copy of the lattice and running sums, predicts one outcome
// per accepted item beat and compares every result beat field by field
// ----------------------------------------------------------------------------
module imf_flip_checker
    import imf_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    imf_item_if                   item,
    imf_result_if                 result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                    flipped;
        logic                    spin_now;
        logic signed [DE_W-1:0]  de;
        logic signed [MAG_W-1:0] mag;
        logic signed [EN_W-1:0]  en;
    } flip_outcome_t;

    bit                  spins [SIDE*SIDE];
    int                  spin_sum;
    int                  bond_energy;
    logic [FRAC_W-1:0]   level_4;
    logic [FRAC_W-1:0]   level_8;
    bit                  antiferro;

    flip_outcome_t       outcome_q [$];
    flip_outcome_t       oldest;

    initial
    begin
        mismatches = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int spin_of(input int unsigned r, input int unsigned c);
        return spins[r*SIDE + c] ? 1 : -1;
    endfunction

    function automatic flip_outcome_t apply_item(
        input logic              cmd,
        input logic [ROW_W-1:0]  row,
        input logic [ROW_W-1:0]  col,
        input logic              load_bit,
        input logic [FRAC_W-1:0] frac
    );
        int unsigned   r;
        int unsigned   c;
        int unsigned   site;
        int            s;
        int            nsum;
        int            ferro;
        int            change;
        int            applied;
        int            en_out;
        logic          take;
        flip_outcome_t o;

        r    = row % SIDE;
        c    = col % SIDE;
        site = r*SIDE + c;
        s    = spins[site] ? 1 : -1;
        nsum = spin_of(r, (c + SIDE - 1) % SIDE) + spin_of(r, (c + 1) % SIDE)
             + spin_of((r + SIDE - 1) % SIDE, c) + spin_of((r + 1) % SIDE, c);
        ferro  = 2 * s * nsum;
        change = antiferro ? -ferro : ferro;

        if (cmd == CMD_ATTEMPT)
        begin
            if (change <= 0)
                take = 1'b1;
            else if (change == 4)
                take = frac < level_4;
            else
                take = frac < level_8;
        end
        else
            take = (spins[site] != load_bit);

        applied = 0;
        if (take)
        begin
            spins[site]  = ~spins[site];
            spin_sum    -= 2 * s;
            bond_energy += ferro;
            applied      = change;
        end
        en_out = antiferro ? -bond_energy : bond_energy;

        o.flipped  = take;
        o.spin_now = spins[site];
        o.de       = applied[DE_W-1:0];
        o.mag      = spin_sum[MAG_W-1:0];
        o.en       = en_out[EN_W-1:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (spins[i])
                spins[i] = 1'b1;
            spin_sum    = SIDE*SIDE;
            bond_energy = -2*SIDE*SIDE;
            level_4     = '0;
            level_8     = '0;
            antiferro   = 1'b0;
            outcome_q.delete();
            in_flight  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LEVEL_4:  level_4   = cfg_data;
                    CFG_LEVEL_8:  level_8   = cfg_data;
                    CFG_COUPLING: antiferro = cfg_data[0];
                    default:      ;
                endcase
            end

            if (result.valid && result.ready)
            begin
                if (outcome_q.size() == 0)
                    report_mismatch("result beat with no item waiting for it");
                else
                begin
                    oldest = outcome_q.pop_front();
                    if (result.flipped !== oldest.flipped)
                        report_mismatch($sformatf("flipped got %0d want %0d",
                                                  result.flipped, oldest.flipped));
                    if (result.spin_now !== oldest.spin_now)
                        report_mismatch($sformatf("spin_now got %0d want %0d",
                                                  result.spin_now, oldest.spin_now));
                    if (result.delta_energy !== oldest.de)
                        report_mismatch($sformatf("delta_energy got %0d want %0d",
                                                  result.delta_energy, oldest.de));
                    if (result.magnetization !== oldest.mag)
                        report_mismatch($sformatf("magnetization got %0d want %0d",
                                                  result.magnetization, oldest.mag));
                    if (result.energy !== oldest.en)
                        report_mismatch($sformatf("energy got %0d want %0d",
                                                  result.energy, oldest.en));
                end
            end

            if (item.valid && item.ready)
                outcome_q.push_back(apply_item(item.cmd, item.row, item.col,
                                               item.spin_value, item.random_fraction));

            in_flight <= outcome_q.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// spin-flip engine testbench: drives load and flip-attempt beats through a
// directed opening and random beats under six register settings, with random
// back-pressure and one long result hold-off; the checker predicts and
// compares every result beat
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imf_pkg::*;

    localparam int SIDE         = SIDE_DEFAULT;
    localparam int SETTLE       = 16;
    localparam int LONG_HOLD    = 80;
    localparam int PHASE_BEATS  = 100;
    localparam int LAST_BEATS   = 130;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatches;
    int                    in_flight;

    bit                    sender_idling;
    bit                    sink_idling;
    bit                    long_hold_go;
    int                    sink_gap;

    logic [FRAC_W-1:0]     cur_level_4;
    logic [FRAC_W-1:0]     cur_level_8;
    int                    n_attempts;
    int                    n_loads;
    int                    n_settings;

    imf_item_if   item_ch ();
    imf_result_if result_ch ();

    ising_metropolis_flip #(
        .SIDE (SIDE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    imf_flip_checker #(
        .SIDE (SIDE)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: random short stalls, or one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        sink_gap = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_go)
            begin
                long_hold_go = 1'b0;
                sink_gap     = LONG_HOLD;
            end
            else if (sink_gap == 0 && sink_idling && $urandom_range(0, 5) == 0)
                sink_gap = $urandom_range(1, 4);
            if (sink_gap > 0)
            begin
                result_ch.ready <= 1'b0;
                sink_gap--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic write_settings(input logic [FRAC_W-1:0] l4, input logic [FRAC_W-1:0] l8,
                                  input logic neg);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LEVEL_4;
        cfg_data  <= l4;
        @(posedge clk);
        cfg_index <= CFG_LEVEL_8;
        cfg_data  <= l8;
        @(posedge clk);
        cfg_index <= CFG_COUPLING;
        cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, neg};
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_level_4 = l4;
        cur_level_8 = l8;
        n_settings++;
    endtask

    task automatic send_beat(input logic cmd, input logic [ROW_W-1:0] row,
                             input logic [ROW_W-1:0] col, input logic spin,
                             input logic [FRAC_W-1:0] frac);
        item_ch.valid           <= 1'b1;
        item_ch.cmd             <= cmd;
        item_ch.row             <= row;
        item_ch.col             <= col;
        item_ch.spin_value      <= spin;
        item_ch.random_fraction <= frac;
        do
            @(negedge clk);
        while (item_ch.ready !== 1'b1);
        @(posedge clk);
        if (cmd == CMD_ATTEMPT)
            n_attempts++;
        else
            n_loads++;
        if (sender_idling && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain;
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (in_flight != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 7))
            0:       return cur_level_4 - 1;
            1:       return cur_level_4;
            2:       return cur_level_8 - 1;
            3:       return cur_level_8;
            4:       return '0;
            5:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly a small window around the wrap corner so loads shape the neighbourhoods
    task automatic random_beat;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             cmd;

        if ($urandom_range(0, 9) < 6)
        begin
            row = ROW_W'(60 + $urandom_range(0, 7));
            col = ROW_W'(60 + $urandom_range(0, 7));
        end
        else
        begin
            row = ROW_W'($urandom);
            col = ROW_W'($urandom);
        end
        cmd = ($urandom_range(0, 99) < 35) ? CMD_LOAD : CMD_ATTEMPT;
        send_beat(cmd, row, col, 1'($urandom_range(0, 1)), pick_fraction());
    endtask

    initial
    begin
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= CFG_LEVEL_4;
        cfg_data                <= '0;
        item_ch.valid           <= 1'b0;
        item_ch.cmd             <= CMD_LOAD;
        item_ch.row             <= '0;
        item_ch.col             <= '0;
        item_ch.spin_value      <= 1'b0;
        item_ch.random_fraction <= '0;
        sender_idling = 1'b1;
        sink_idling   = 1'b1;
        long_hold_go  = 1'b0;
        n_attempts    = 0;
        n_loads       = 0;
        n_settings    = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ferromagnetic, nothing uphill accepted
        write_settings('0, '0, 1'b0);
        send_beat(CMD_ATTEMPT, 6'd0, 6'd0, 1'b0, '0);
        send_beat(CMD_LOAD, 6'd5, 6'd5, 1'b1, '0);
        send_beat(CMD_LOAD, 6'd0, 6'd0, 1'b0, '0);
        send_beat(CMD_ATTEMPT, 6'd0, 6'd0, 1'b0, '1);
        send_beat(CMD_LOAD, 6'd10, 6'd11, 1'b0, '0);
        send_beat(CMD_ATTEMPT, 6'd10, 6'd10, 1'b1, '0);
        send_beat(CMD_ATTEMPT, 6'd63, 6'd63, 1'b0, '1);
        send_beat(CMD_ATTEMPT, 6'd0, 6'd63, 1'b1, '1);
        send_beat(CMD_LOAD, 6'd63, 6'd0, 1'b0, '1);
        send_beat(CMD_ATTEMPT, 6'd0, 6'd0, 1'b1, '0);
        drain();

        // everything uphill accepted except at the very top of the fraction range
        write_settings('1, '1, 1'b0);
        send_beat(CMD_ATTEMPT, 6'd0, 6'd0, 1'b0, 32'hFFFF_FFFF);
        send_beat(CMD_ATTEMPT, 6'd0, 6'd0, 1'b0, 32'hFFFF_FFFE);
        send_beat(CMD_ATTEMPT, 6'd5, 6'd5, 1'b0, 32'hFFFF_FFFE);
        send_beat(CMD_ATTEMPT, 6'd5, 6'd5, 1'b0, 32'hFFFF_FFFF);
        drain();

        // antiferromagnetic coupling
        write_settings(32'h8000_0000, 32'h0000_0001, 1'b1);
        send_beat(CMD_ATTEMPT, 6'd20, 6'd20, 1'b0, '1);
        send_beat(CMD_ATTEMPT, 6'd20, 6'd20, 1'b0, '0);
        send_beat(CMD_ATTEMPT, 6'd20, 6'd20, 1'b0, '1);
        send_beat(CMD_ATTEMPT, 6'd20, 6'd20, 1'b0, 32'h0000_0001);
        send_beat(CMD_LOAD, 6'd30, 6'd30, 1'b0, '0);
        send_beat(CMD_LOAD, 6'd30, 6'd31, 1'b0, '0);
        send_beat(CMD_ATTEMPT, 6'd30, 6'd30, 1'b1, 32'h7FFF_FFFF);
        send_beat(CMD_LOAD, 6'd30, 6'd31, 1'b1, '0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       write_settings('1, '1, 1'b0);
                1:       write_settings($urandom, $urandom, 1'b0);
                2:       write_settings($urandom, $urandom, 1'b1);
                3:       write_settings('0, '1, 1'b1);
                4:       write_settings('1, '0, 1'b0);
                default: write_settings($urandom, $urandom, 1'($urandom_range(0, 1)));
            endcase
            if (phase == 2)
            begin
                // receiver holds off while the sender keeps pushing beats
                sender_idling = 1'b0;
                long_hold_go  = 1'b1;
            end
            else if (phase == 5)
            begin
                sender_idling = 1'b0;
                sink_idling   = 1'b0;
            end
            else
                sender_idling = 1'b1;
            repeat (phase == 5 ? LAST_BEATS : PHASE_BEATS) random_beat();
            drain();
        end

        $display("covered %0d load and %0d flip-attempt beats over %0d register settings,",
                 n_loads, n_attempts, n_settings);
        $display("with random stalls on both sides and one long result hold-off");
        if (mismatches == 0 && in_flight == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/imf_pkg.sv
rtl/core/imf_item_if.sv
rtl/core/imf_result_if.sv
rtl/core/imf_sequencer.sv
rtl/core/ising_metropolis_flip.sv
dv/imf_flip_checker.sv
dv/tb.sv
